### rtl/core/gateway_discovery_table_defines.svh
// Assertion macros shared by the gateway discovery table RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef GATEWAY_DISCOVERY_TABLE_DEFINES_SVH
`define GATEWAY_DISCOVERY_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GDT_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("gateway discovery table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GDT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("gateway discovery table: next-cycle check failed");

`endif

### rtl/core/gdt_pkg.sv
// Types and constants of the gateway discovery table.
// Used by gdt_entry_unit and gateway_discovery_table; depends on nothing.
`default_nettype none

package gdt_pkg;

  localparam int MAC_W       = 48;
  localparam int IP_W        = 32;
  localparam int TTL_W       = 8;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 4;
  localparam int INDEX_W     = 4;
  localparam int PHASE_W     = 2;
  localparam int EXPIRED_W   = 5;
  localparam int CFG_INDEX_W = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLIENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SERVER = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 4'd0;
  localparam logic [STATUS_W-1:0] STATUS_CREATED   = 4'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXISTS    = 4'd2;
  localparam logic [STATUS_W-1:0] STATUS_COMMITTED = 4'd3;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 4'd4;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 4'd5;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY   = 4'd6;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 4'd7;
  localparam logic [STATUS_W-1:0] STATUS_TICK_DONE = 4'd8;

  // Entry phases.
  localparam logic [PHASE_W-1:0] PHASE_PRETENDER = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_COMMITTED = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_RECHECK   = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] CFG_TTL_INITIAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TTL_RECHECK = 2'd1;
  localparam logic [TTL_W-1:0] TTL_INITIAL_RESET = 8'd60;
  localparam logic [TTL_W-1:0] TTL_RECHECK_RESET = 8'd10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              discovery_enabled;
    logic [MAC_W-1:0]  dest_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [IP_W-1:0]   ip_address;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   entry_index;
    logic [PHASE_W-1:0]   entry_phase;
    logic [EXPIRED_W-1:0] expired_count;
  } result_t;

  // One table row as held in the entry memory.
  typedef struct packed {
    logic [MAC_W-1:0]   gateway_mac;
    logic [MAC_W-1:0]   client_mac;
    logic [IP_W-1:0]    client_ip;
    logic [PHASE_W-1:0] phase;
    logic [TTL_W-1:0]   ttl;
  } entry_t;

  // Compare and ageing results of the entry unit for one row.
  typedef struct packed {
    logic               key_hit;
    logic               client_ok;
    logic [TTL_W-1:0]   aged_ttl;
    logic [PHASE_W-1:0] aged_phase;
    logic               expires;
  } unit_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/gateway_discovery_table.sv
// Gateway discovery table. Every tick and every enabled client or server
// packet sweeps the ENTRIES rows of the entry memory, one row per cycle
// through the one read port, in a single compare and ageing unit. A tick
// writes back each live row with its aged TTL and phase; a packet then
// decides and writes back at most one row. An ignored packet skips the sweep.
// Only one item is in work at a time: item_stall is low only while the block
// is idle. Row valid bits are flip-flops cleared by reset, so no clearing
// pass is needed after reset. Configuration writes are taken while the block
// is idle.
`default_nettype none
`include "gateway_discovery_table_defines.svh"

module gateway_discovery_table #(
  parameter int ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Item channel.
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire gdt_pkg::item_t                    item,
  // Result channel.
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output gdt_pkg::result_t                       result,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gdt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [gdt_pkg::TTL_W-1:0]         cfg_data
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = $bits(gdt_pkg::entry_t);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES);

  gdt_pkg::state_t state, state_next;

  logic [gdt_pkg::TTL_W-1:0] ttl_initial;
  logic [gdt_pkg::TTL_W-1:0] ttl_recheck;
  logic [ENTRIES-1:0]        entry_valid;
  gdt_pkg::item_t            item_reg;

  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             pend_live;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  gdt_pkg::entry_t  hit_entry;
  logic             hit_ok;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] expired;

  logic             accept;
  logic             skip;
  logic             issuing;
  logic [IDX_W-1:0] issue_idx;
  logic             is_tick;
  logic             is_client;
  logic             is_server;
  logic             age_row;
  logic             out_free;
  logic             fire;
  logic             do_create;
  logic             do_commit;
  logic [IDX_W-1:0] res_idx;
  logic [IDX_W+3:0] idx_ext;
  logic [CNT_W+4:0] exp_ext;
  gdt_pkg::result_t res_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  gdt_pkg::entry_t  ram_wdata;
  gdt_pkg::entry_t  ram_rdata;
  gdt_pkg::unit_res_t ures;

  // Item decode.
  assign is_tick   = (item_reg.kind == gdt_pkg::KIND_TICK);
  assign is_client = (item_reg.kind == gdt_pkg::KIND_CLIENT) && item_reg.discovery_enabled;
  assign is_server = (item_reg.kind == gdt_pkg::KIND_SERVER) && item_reg.discovery_enabled;
  assign skip      = !((item.kind == gdt_pkg::KIND_TICK) ||
                       (((item.kind == gdt_pkg::KIND_CLIENT) ||
                         (item.kind == gdt_pkg::KIND_SERVER)) && item.discovery_enabled));

  // Handshakes; nothing is taken while reset is held.
  assign item_stall = rst || (state != gdt_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = !rst && (state == gdt_pkg::ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign fire       = (state == gdt_pkg::ST_WRITE) && out_free;

  // Row sweep: one read issued per cycle, its data checked in the next cycle.
  assign issuing   = (state == gdt_pkg::ST_SCAN) && (cnt != LAST);
  assign issue_idx = cnt[IDX_W-1:0];
  assign age_row   = (state == gdt_pkg::ST_SCAN) && pend && pend_live && is_tick;

  gdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issuing),
    .raddr (issue_idx),
    .rdata (ram_rdata)
  );

  gdt_entry_unit u_unit (
    .entry       (ram_rdata),
    .item        (item_reg),
    .ttl_recheck (ttl_recheck),
    .res         (ures)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gdt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = skip ? gdt_pkg::ST_WRITE : gdt_pkg::ST_SCAN;
        end
      end
      gdt_pkg::ST_SCAN: begin
        if (cnt == LAST) begin
          state_next = gdt_pkg::ST_WRITE;
        end
      end
      gdt_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = gdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gdt_pkg::ST_IDLE;
      end
    endcase
  end

  // Decision for the finished sweep.
  always_comb begin
    res_next  = '0;
    res_idx   = '0;
    do_create = 1'b0;
    do_commit = 1'b0;
    res_next.status = gdt_pkg::STATUS_IGNORED;
    if (is_tick) begin
      res_next.status = gdt_pkg::STATUS_TICK_DONE;
    end else if (is_client) begin
      if (found) begin
        res_next.status      = gdt_pkg::STATUS_EXISTS;
        res_idx              = hit_idx;
        res_next.entry_phase = hit_entry.phase;
      end else if (free_found) begin
        res_next.status      = gdt_pkg::STATUS_CREATED;
        res_idx              = free_idx;
        res_next.entry_phase = gdt_pkg::PHASE_PRETENDER;
        do_create            = 1'b1;
      end else begin
        res_next.status = gdt_pkg::STATUS_FULL;
      end
    end else if (is_server) begin
      if (!found) begin
        res_next.status = gdt_pkg::STATUS_UNKNOWN;
      end else begin
        res_idx = hit_idx;
        if ((hit_entry.phase == gdt_pkg::PHASE_PRETENDER) ||
            (hit_entry.phase == gdt_pkg::PHASE_RECHECK)) begin
          if (hit_ok) begin
            res_next.status      = gdt_pkg::STATUS_COMMITTED;
            res_next.entry_phase = gdt_pkg::PHASE_COMMITTED;
            do_commit            = 1'b1;
          end else begin
            res_next.status      = gdt_pkg::STATUS_MISMATCH;
            res_next.entry_phase = hit_entry.phase;
          end
        end else begin
          res_next.status      = gdt_pkg::STATUS_ALREADY;
          res_next.entry_phase = hit_entry.phase;
        end
      end
    end
    idx_ext = {4'b0, res_idx};
    exp_ext = {5'b0, expired};
    res_next.entry_index   = idx_ext[3:0];
    res_next.expired_count = is_tick ? exp_ext[4:0] : '0;
  end

  // Memory write: aged row during a tick sweep, new or committed row after.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = ram_rdata;
    if (age_row) begin
      ram_we               = 1'b1;
      ram_wdata.phase      = ures.aged_phase;
      ram_wdata.ttl        = ures.aged_ttl;
    end else if (fire && do_create) begin
      ram_we                = 1'b1;
      ram_waddr             = free_idx;
      ram_wdata.gateway_mac = item_reg.dest_mac;
      ram_wdata.client_mac  = item_reg.src_mac;
      ram_wdata.client_ip   = item_reg.ip_address;
      ram_wdata.phase       = gdt_pkg::PHASE_PRETENDER;
      ram_wdata.ttl         = ttl_initial;
    end else if (fire && do_commit) begin
      ram_we          = 1'b1;
      ram_waddr       = hit_idx;
      ram_wdata       = hit_entry;
      ram_wdata.phase = gdt_pkg::PHASE_COMMITTED;
      ram_wdata.ttl   = ttl_initial;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_initial <= gdt_pkg::TTL_INITIAL_RESET;
      ttl_recheck <= gdt_pkg::TTL_RECHECK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gdt_pkg::CFG_TTL_INITIAL: ttl_initial <= cfg_data;
        gdt_pkg::CFG_TTL_RECHECK: ttl_recheck <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row valid bits: set on creation, cleared when a tick expires the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (age_row && ures.expires) begin
      entry_valid[pend_idx] <= 1'b0;
    end else if (fire && do_create) begin
      entry_valid[free_idx] <= 1'b1;
    end
  end

  // Sweep control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      expired    <= '0;
    end else if (accept) begin
      cnt        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      expired    <= '0;
    end else if (state == gdt_pkg::ST_SCAN) begin
      pend <= issuing;
      if (issuing) begin
        cnt <= cnt + 1'b1;
      end
      if (issuing && !entry_valid[issue_idx] && !free_found) begin
        free_found <= 1'b1;
      end
      if (pend && pend_live && !is_tick && ures.key_hit && !found) begin
        found <= 1'b1;
      end
      if (age_row && ures.expires) begin
        expired <= expired + 1'b1;
      end
    end
  end

  // Sweep payload: item copy, pending row and captured hit.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg <= item;
    end
    if (issuing) begin
      pend_idx  <= issue_idx;
      pend_live <= entry_valid[issue_idx];
      if (!entry_valid[issue_idx] && !free_found) begin
        free_idx <= issue_idx;
      end
    end
    if ((state == gdt_pkg::ST_SCAN) && pend && pend_live && !is_tick &&
        ures.key_hit && !found) begin
      hit_idx   <= pend_idx;
      hit_entry <= ram_rdata;
      hit_ok    <= ures.client_ok;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

  // Checks on the sequencer.
  `GDT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != gdt_pkg::ST_IDLE)
  `GDT_ASSERT_IMPLY(a_ram_write_busy, clk, rst, ram_we, state != gdt_pkg::ST_IDLE)
  `GDT_ASSERT_IMPLY(a_expired_bounded, clk, rst, state == gdt_pkg::ST_WRITE, expired <= LAST)
  `GDT_ASSERT_NEXT(a_result_from_write, clk, rst, !result_valid && (state != gdt_pkg::ST_WRITE), !result_valid)

endmodule

`default_nettype wire

### rtl/core/gdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/gdt_entry_unit.sv
// Shared compare and ageing unit: checks one table row against the current
// item and works out its aged TTL and phase. Depends on gdt_pkg.
`default_nettype none

module gdt_entry_unit (
  input  wire gdt_pkg::entry_t            entry,
  input  wire gdt_pkg::item_t             item,
  input  wire logic [gdt_pkg::TTL_W-1:0]  ttl_recheck,
  output gdt_pkg::unit_res_t              res
);

  logic [gdt_pkg::MAC_W-1:0] key;
  logic [gdt_pkg::TTL_W-1:0] aged;

  // Client packets look up the destination, server packets the source.
  assign key = (item.kind == gdt_pkg::KIND_CLIENT) ? item.dest_mac : item.src_mac;

  // A TTL saturates at zero.
  assign aged = (entry.ttl == '0) ? '0 : entry.ttl - 1'b1;

  always_comb begin
    res.key_hit    = (entry.gateway_mac == key);
    res.client_ok  = (entry.client_ip == item.ip_address) &&
                     (entry.client_mac == item.dest_mac);
    res.aged_ttl   = aged;
    res.aged_phase = (aged <= ttl_recheck) ? gdt_pkg::PHASE_RECHECK : entry.phase;
    res.expires    = (aged == '0);
  end

endmodule

`default_nettype wire

### tb/gateway_discovery_table_tb.sv
// Self-checking testbench for the gateway discovery table: directed cases, ageing,
// a full table, back-pressure and random traffic against an in-bench table predictor.
// Depends on gdt_pkg and the gateway_discovery_table RTL only.
module gateway_discovery_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES       = 16;
  localparam int POOL_SIZE     = 24;
  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                            clk;
  logic                            rst;
  logic                            item_valid;
  logic                            item_stall;
  gdt_pkg::item_t                  item;
  logic                            result_valid;
  logic                            result_stall;
  gdt_pkg::result_t                result;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [gdt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gdt_pkg::TTL_W-1:0]       cfg_data;

  // Predicted table contents and register copies.
  bit                          tbl_valid       [ENTRIES];
  logic [gdt_pkg::MAC_W-1:0]   tbl_gateway     [ENTRIES];
  logic [gdt_pkg::MAC_W-1:0]   tbl_client_mac  [ENTRIES];
  logic [gdt_pkg::IP_W-1:0]    tbl_client_ip   [ENTRIES];
  logic [gdt_pkg::PHASE_W-1:0] tbl_phase       [ENTRIES];
  logic [gdt_pkg::TTL_W-1:0]   tbl_ttl         [ENTRIES];
  logic [gdt_pkg::TTL_W-1:0]   ttl_initial_reg;
  logic [gdt_pkg::TTL_W-1:0]   ttl_recheck_reg;

  // Candidate gateway/client pairings used to build well-formed packet sequences.
  logic [gdt_pkg::MAC_W-1:0]   pool_gateway    [POOL_SIZE];
  logic [gdt_pkg::MAC_W-1:0]   pool_client_mac [POOL_SIZE];
  logic [gdt_pkg::IP_W-1:0]    pool_client_ip  [POOL_SIZE];

  gdt_pkg::result_t predicted_outcomes[$];
  int      mismatch_count;
  int      handled_items;
  int      cycle_count;
  int      hold_cycles;
  bit      sender_idles;
  bit      receiver_idles;

  gateway_discovery_table #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run if it has not finished within the cycle limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("gateway_discovery_table: mismatch");
    $finish;
  end

  function automatic logic [gdt_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[gdt_pkg::MAC_W-1:0];
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_idle_length();
    if ($urandom_range(99) < 85) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic gdt_pkg::item_t make_item(input logic [gdt_pkg::KIND_W-1:0] kind,
                                               input logic enabled,
                                               input logic [gdt_pkg::MAC_W-1:0] dmac,
                                               input logic [gdt_pkg::MAC_W-1:0] smac,
                                               input logic [gdt_pkg::IP_W-1:0] ip);
    gdt_pkg::item_t it;
    it.kind              = kind;
    it.discovery_enabled = enabled;
    it.dest_mac          = dmac;
    it.src_mac           = smac;
    it.ip_address        = ip;
    return it;
  endfunction

  function automatic int find_gateway(input logic [gdt_pkg::MAC_W-1:0] mac);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_gateway[i] == mac) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic bit table_occupied();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one accepted item to the predicted table and returns the result it must give.
  function automatic gdt_pkg::result_t table_predict(input gdt_pkg::item_t it);
    gdt_pkg::result_t r;
    int      slot;
    int      i;
    r = '0;
    case (it.kind)
      gdt_pkg::KIND_TICK: begin
        // Age every live row; rows reaching zero are freed.
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_ttl[i] != 0) begin
              tbl_ttl[i] = tbl_ttl[i] - 1'b1;
            end
            if (tbl_ttl[i] <= ttl_recheck_reg) begin
              tbl_phase[i] = gdt_pkg::PHASE_RECHECK;
            end
            if (tbl_ttl[i] == 0) begin
              tbl_valid[i]    = 1'b0;
              r.expired_count = r.expired_count + 1'b1;
            end
          end
        end
        r.status = gdt_pkg::STATUS_TICK_DONE;
      end
      gdt_pkg::KIND_CLIENT: begin
        if (it.discovery_enabled) begin
          slot = find_gateway(it.dest_mac);
          if (slot >= 0) begin
            r.status      = gdt_pkg::STATUS_EXISTS;
            r.entry_index = gdt_pkg::INDEX_W'(slot);
            r.entry_phase = tbl_phase[slot];
          end else begin
            // Lowest free row wins.
            for (i = ENTRIES - 1; i >= 0; i--) begin
              if (!tbl_valid[i]) begin
                slot = i;
              end
            end
            if (slot < 0) begin
              r.status = gdt_pkg::STATUS_FULL;
            end else begin
              tbl_valid[slot]      = 1'b1;
              tbl_gateway[slot]    = it.dest_mac;
              tbl_client_mac[slot] = it.src_mac;
              tbl_client_ip[slot]  = it.ip_address;
              tbl_ttl[slot]        = ttl_initial_reg;
              tbl_phase[slot]      = gdt_pkg::PHASE_PRETENDER;
              r.status             = gdt_pkg::STATUS_CREATED;
              r.entry_index        = gdt_pkg::INDEX_W'(slot);
              r.entry_phase        = gdt_pkg::PHASE_PRETENDER;
            end
          end
        end
      end
      gdt_pkg::KIND_SERVER: begin
        if (it.discovery_enabled) begin
          slot = find_gateway(it.src_mac);
          if (slot < 0) begin
            r.status = gdt_pkg::STATUS_UNKNOWN;
          end else begin
            r.entry_index = gdt_pkg::INDEX_W'(slot);
            if (tbl_phase[slot] == gdt_pkg::PHASE_PRETENDER ||
                tbl_phase[slot] == gdt_pkg::PHASE_RECHECK) begin
              if (tbl_client_ip[slot] == it.ip_address &&
                  tbl_client_mac[slot] == it.dest_mac) begin
                tbl_phase[slot] = gdt_pkg::PHASE_COMMITTED;
                tbl_ttl[slot]   = ttl_initial_reg;
                r.status        = gdt_pkg::STATUS_COMMITTED;
              end else begin
                r.status = gdt_pkg::STATUS_MISMATCH;
              end
            end else begin
              r.status = gdt_pkg::STATUS_ALREADY;
            end
            r.entry_phase = tbl_phase[slot];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void refresh_pool_entry(input int p);
    pool_gateway[p]    = rand_mac();
    pool_client_mac[p] = rand_mac();
    pool_client_ip[p]  = $urandom();
  endfunction

  // Mostly well-formed client/server sequences from the pool, plus ticks and noise.
  function automatic gdt_pkg::item_t random_item();
    gdt_pkg::item_t            it;
    int                        p;
    int                        r;
    logic [gdt_pkg::MAC_W-1:0] cm;
    logic [gdt_pkg::IP_W-1:0]  ip;
    p = $urandom_range(POOL_SIZE - 1);
    if ($urandom_range(49) == 0) begin
      refresh_pool_entry(p);
    end
    cm = pool_client_mac[p];
    ip = pool_client_ip[p];
    r  = $urandom_range(99);
    if (r < 35) begin
      it = make_item(gdt_pkg::KIND_CLIENT, 1'b1, pool_gateway[p], cm, ip);
    end else if (r < 65) begin
      it = make_item(gdt_pkg::KIND_SERVER, 1'b1, cm, pool_gateway[p], ip);
      // Roughly a third of server packets are broken in one way.
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(2))
          0: it.ip_address = ip ^ (32'd1 << $urandom_range(gdt_pkg::IP_W - 1));
          1: it.dest_mac   = cm ^ (48'd1 << $urandom_range(gdt_pkg::MAC_W - 1));
          default: it.src_mac = rand_mac();
        endcase
      end
    end else if (r < 80) begin
      it = make_item(gdt_pkg::KIND_TICK, 1'($urandom_range(1)), rand_mac(), rand_mac(),
                     $urandom());
    end else begin
      it = make_item(gdt_pkg::KIND_W'($urandom_range(3)), 1'($urandom_range(1)), rand_mac(),
                     rand_mac(), $urandom());
    end
    return it;
  endfunction

  // Optional idle stretch on the item channel after a transaction.
  task automatic sender_pause();
    int n;
    n = 0;
    if (sender_idles && $urandom_range(99) < 40) begin
      n = pick_idle_length();
    end
    if (n > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offers one item, waits for the transaction and records the result it must produce.
  task automatic send_item(input gdt_pkg::item_t it);
    gdt_pkg::result_t outcome;
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    outcome = table_predict(it);
    predicted_outcomes.push_back(outcome);
    if (outcome.status != gdt_pkg::STATUS_IGNORED) begin
      handled_items++;
    end
    sender_pause();
  endtask

  // Drops the item channel and waits for every outstanding result, then lets the block settle.
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [gdt_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [gdt_pkg::TTL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == gdt_pkg::CFG_TTL_INITIAL) begin
      ttl_initial_reg = value;
    end else if (idx == gdt_pkg::CFG_TTL_RECHECK) begin
      ttl_recheck_reg = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ttls(input logic [gdt_pkg::TTL_W-1:0] initial_ttl,
                          input logic [gdt_pkg::TTL_W-1:0] recheck_ttl);
    drain_results();
    write_register(gdt_pkg::CFG_TTL_INITIAL, initial_ttl);
    write_register(gdt_pkg::CFG_TTL_RECHECK, recheck_ttl);
  endtask

  // Ticks until the predicted table is empty.
  task automatic flush_table();
    while (table_occupied()) begin
      send_item(make_item(gdt_pkg::KIND_TICK, 1'b0, '0, '0, '0));
    end
    drain_results();
  endtask

  // Directed packet cases under the reset register values.
  task automatic test_packet_cases();
    logic [gdt_pkg::MAC_W-1:0] gw;
    logic [gdt_pkg::MAC_W-1:0] cm;
    logic [gdt_pkg::IP_W-1:0]  ip;
    gw = rand_mac();
    cm = rand_mac();
    ip = $urandom();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    send_item(make_item(2'd3, 1'b1, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b0, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b0, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_TICK, 1'b1, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, '0, '0, '0));
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, '1, '0, '0));
    // Server packets against the all-ones gateway: wrong IP, wrong client MAC, then a match.
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, '1, '1, 32'hFFFF_FFFE));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, 48'h7FFF_FFFF_FFFF, '1, '1));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, '1, '1, '1));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, '0, '0, '0));
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, gw, cm, ip));
    send_item(make_item(gdt_pkg::KIND_TICK, 1'b0, '0, '0, '0));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, cm, gw, ip));
    send_item(make_item(2'd3, 1'b0, '0, '0, '0));
    send_item(make_item(gdt_pkg::KIND_TICK, 1'b1, '0, '0, '0));
    drain_results();
  endtask

  // Recheck marking, commit out of recheck, zero initial TTL and expiry.
  task automatic test_aging();
    logic [gdt_pkg::MAC_W-1:0] gw;
    logic [gdt_pkg::MAC_W-1:0] cm;
    logic [gdt_pkg::IP_W-1:0]  ip;
    gw = rand_mac();
    cm = rand_mac();
    ip = $urandom();
    set_ttls(8'd255, 8'd255);
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, gw, cm, ip));
    send_item(make_item(gdt_pkg::KIND_TICK, 1'b1, '0, '0, '0));
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, gw, cm, ip));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, cm, gw, ip));
    send_item(make_item(gdt_pkg::KIND_TICK, 1'b1, '0, '0, '0));
    // A zero initial TTL lives until the next tick only.
    set_ttls(8'd0, 8'd0);
    gw = rand_mac();
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, gw, cm, ip));
    send_item(make_item(gdt_pkg::KIND_TICK, 1'b1, '0, '0, '0));
    set_ttls(8'd3, 8'd1);
    gw = rand_mac();
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, gw, cm, ip));
    repeat (3) send_item(make_item(gdt_pkg::KIND_TICK, 1'b0, '0, '0, '0));
    flush_table();
  endtask

  // Fill every row, then one more gateway is refused.
  task automatic test_table_full();
    int i;
    flush_table();
    set_ttls(8'd20, 8'd10);
    for (i = 0; i <= ENTRIES; i++) begin
      send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, {16'hA5A5, 32'(i)}, rand_mac(),
                          $urandom()));
    end
    send_item(make_item(gdt_pkg::KIND_CLIENT, 1'b1, {16'hA5A5, 32'd0}, rand_mac(), $urandom()));
    send_item(make_item(gdt_pkg::KIND_SERVER, 1'b1, rand_mac(), rand_mac(), $urandom()));
    flush_table();
  endtask

  // The receiver holds off for a long stretch while items keep coming back to back.
  task automatic test_backpressure();
    int i;
    set_ttls(8'd8, 8'd3);
    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    hold_cycles    = 300;
    for (i = 0; i < 20; i++) begin
      send_item(random_item());
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int count,
                                     input logic [gdt_pkg::TTL_W-1:0] initial_ttl,
                                     input logic [gdt_pkg::TTL_W-1:0] recheck_ttl,
                                     input bit idles);
    int target;
    set_ttls(initial_ttl, recheck_ttl);
    sender_idles   = idles;
    receiver_idles = idles;
    target         = handled_items + count;
    while (handled_items < target) begin
      send_item(random_item());
    end
    drain_results();
  endtask

  // Result stall: long hold-offs on request, otherwise random stretches when enabled.
  initial begin
    int run;
    run          = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_stall <= 1'b1;
        hold_cycles--;
      end else if (run > 0) begin
        result_stall <= 1'b1;
        run--;
      end else if (receiver_idles && $urandom_range(99) < 25) begin
        result_stall <= 1'b1;
        run = pick_idle_length() - 1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    gdt_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_outcomes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result status=%0d index=%0d phase=%0d expired=%0d", $time,
                 result.status, result.entry_index, result.entry_phase, result.expired_count);
      end else begin
        want = predicted_outcomes.pop_front();
        if (result !== want) begin
          mismatch_count++;
          $display("%0t: expected status=%0d index=%0d phase=%0d expired=%0d", $time,
                   want.status, want.entry_index, want.entry_phase, want.expired_count);
          $display("%0t:   actual status=%0d index=%0d phase=%0d expired=%0d", $time,
                   result.status, result.entry_index, result.entry_phase, result.expired_count);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    int i;
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_cycles    = 0;
    mismatch_count = 0;
    handled_items  = 0;
    ttl_initial_reg = gdt_pkg::TTL_INITIAL_RESET;
    ttl_recheck_reg = gdt_pkg::TTL_RECHECK_RESET;
    for (i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
    end
    for (i = 0; i < POOL_SIZE; i++) begin
      refresh_pool_entry(i);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_packet_cases();
    test_aging();
    test_table_full();
    test_backpressure();
    test_random_traffic(180, 8'd8, 8'd3, 1'b1);
    test_random_traffic(140, 8'd3, 8'd0, 1'b0);
    test_random_traffic(70, 8'd1, 8'd0, 1'b1);
    test_random_traffic(140, 8'd25, 8'd8, 1'b1);
    test_random_traffic(100, 8'd255, 8'd254, 1'b1);
    flush_table();
    test_random_traffic(60, 8'd0, 8'd255, 1'b1);
    test_random_traffic(100, gdt_pkg::TTL_INITIAL_RESET, gdt_pkg::TTL_RECHECK_RESET, 1'b0);
    drain_results();

    if (mismatch_count == 0) begin
      $display("gateway_discovery_table: match");
    end else begin
      $display("gateway_discovery_table: mismatch");
    end
    $finish;
  end

endmodule
